>>> sv/excitation_occupation_factor_defines.svh
// Assertion macros shared by the excitation occupation factor RTL.
`ifndef EXCITATION_OCCUPATION_FACTOR_DEFINES_SVH
`define EXCITATION_OCCUPATION_FACTOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define EOF_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define EOF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/eof_pkg.sv
// Shared types, codes and decode functions for the excitation occupation factor block.
package eof_pkg;

   localparam int SITES_DEFAULT = 64;
   localparam int SITE_W        = 6;
   localparam int SITE_CODES    = 64;

   // request types
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_EVAL  = 1'b1;

   // commutation modes
   localparam logic [2:0] MODE_NONE    = 3'd0;
   localparam logic [2:0] MODE_CA      = 3'd1;
   localparam logic [2:0] MODE_AC      = 3'd2;
   localparam logic [2:0] MODE_CA_XFER = 3'd3;
   localparam logic [2:0] MODE_AC_XFER = 3'd4;

   // excitation types (O = other-spin term, S = same-spin term)
   localparam logic [2:0] EXC_NONE   = 3'd0;
   localparam logic [2:0] EXC_OA     = 3'd1;
   localparam logic [2:0] EXC_SASB   = 3'd2;
   localparam logic [2:0] EXC_OAOB   = 3'd3;
   localparam logic [2:0] EXC_OASB   = 3'd4;
   localparam logic [2:0] EXC_OISASB = 3'd5;
   localparam logic [2:0] EXC_OIOAOB = 3'd6;
   localparam logic [2:0] EXC_OIOASB = 3'd7;

   // term site selects
   localparam logic [1:0] SEL_A = 2'd0;
   localparam logic [1:0] SEL_B = 2'd1;
   localparam logic [1:0] SEL_I = 2'd2;

   typedef struct packed {
      logic [1:0] site_sel;
      logic       same;
   } eof_term_type;

   typedef struct packed {
      logic       load;
      logic       clr_step;
      logic       wr_en;
      logic       rd_en;
      logic       acc_en;
      logic       finish;
      logic [1:0] term_idx;
   } eof_cmd_type;

   typedef struct packed {
      logic       is_write;
      logic       mode_bad;
      logic [1:0] term_count;
      logic       clr_last;
   } eof_status_type;

   function automatic logic [1:0] term_count(input logic [2:0] exc, input logic same_site);
      logic [1:0] cnt;
      unique case (exc)
         EXC_NONE:                      cnt = 2'd0;
         EXC_OA:                        cnt = 2'd1;
         EXC_SASB:                      cnt = same_site ? 2'd1 : 2'd2;
         EXC_OAOB, EXC_OASB:            cnt = 2'd2;
         EXC_OISASB, EXC_OIOAOB,
         EXC_OIOASB:                    cnt = 2'd3;
         default:                       cnt = 2'd0;
      endcase
      return cnt;
   endfunction

   function automatic eof_term_type term_desc(input logic [2:0] exc, input logic [1:0] k);
      eof_term_type d;
      d.site_sel = SEL_A;
      d.same     = 1'b0;
      unique case (exc)
         EXC_SASB: begin
            d.site_sel = (k == 2'd0) ? SEL_A : SEL_B;
            d.same     = 1'b1;
         end
         EXC_OAOB: begin
            d.site_sel = (k == 2'd0) ? SEL_A : SEL_B;
         end
         EXC_OASB: begin
            d.site_sel = (k == 2'd0) ? SEL_A : SEL_B;
            d.same     = (k != 2'd0);
         end
         EXC_OISASB, EXC_OIOAOB, EXC_OIOASB: begin
            unique case (k)
               2'd0:    d.site_sel = SEL_I;
               2'd1:    d.site_sel = SEL_A;
               default: d.site_sel = SEL_B;
            endcase
            if (exc == EXC_OISASB) begin
               d.same = (k != 2'd0);
            end else if (exc == EXC_OIOASB) begin
               d.same = (k == 2'd2);
            end
         end
         default: begin
            d.site_sel = SEL_A;
            d.same     = 1'b0;
         end
      endcase
      return d;
   endfunction

endpackage

>>> sv/eof_datapath.sv
// Datapath: request registers, occupancy memory, term arithmetic and result registers.
module eof_datapath #(
   parameter int SITES = eof_pkg::SITES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  eof_pkg::eof_cmd_type   cmd,
   output eof_pkg::eof_status_type status,
   input  logic                   req_type,
   input  logic                   req_occ_value,
   input  logic [2:0]             req_mode,
   input  logic [2:0]             req_exc_type,
   input  logic [5:0]             req_site_a,
   input  logic [5:0]             req_site_b,
   input  logic [5:0]             req_site_i,
   input  logic [5:0]             req_site_j,
   input  logic                   req_spin_s,
   input  logic [5:0]             req_site_m,
   input  logic [5:0]             req_site_n,
   input  logic                   req_spin_u,
   output logic signed [5:0]      rsp_factor,
   output logic                   rsp_bad_mode
);

   localparam int Depth = 2 * SITES;
   localparam int AddrW = $clog2(Depth);
   localparam logic [AddrW-1:0] SpinOff  = AddrW'(SITES);
   localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

   // site modulo SITES, worked out at elaboration
   logic [AddrW-1:0] site_mod [eof_pkg::SITE_CODES];
   for (genvar k = 0; k < eof_pkg::SITE_CODES; k++) begin : g_mod
      localparam int ModK = k % SITES;
      assign site_mod[k] = AddrW'(ModK);
   end

   // request registers
   logic       type_ff, occ_ff, spin_s_ff, spin_u_ff;
   logic [2:0] mode_ff, exc_ff;
   logic [5:0] site_a_ff, site_b_ff, site_i_ff, site_j_ff, site_m_ff, site_n_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff   <= req_type;
         occ_ff    <= req_occ_value;
         mode_ff   <= req_mode;
         exc_ff    <= req_exc_type;
         site_a_ff <= req_site_a;
         site_b_ff <= req_site_b;
         site_i_ff <= req_site_i;
         site_j_ff <= req_site_j;
         spin_s_ff <= req_spin_s;
         site_m_ff <= req_site_m;
         site_n_ff <= req_site_n;
         spin_u_ff <= req_spin_u;
      end
   end

   // clear sweep counter
   logic [AddrW-1:0] clr_addr_ff, clr_addr_in;

   always_comb begin
      clr_addr_in = clr_addr_ff;
      if (cmd.clr_step) begin
         clr_addr_in = clr_addr_ff + AddrW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else begin
         clr_addr_ff <= clr_addr_in;
      end
   end

   // current term
   eof_pkg::eof_term_type desc;
   logic [5:0]            term_site;
   logic                  term_spin;

   always_comb begin
      desc = eof_pkg::term_desc(exc_ff, cmd.term_idx);
      unique case (desc.site_sel)
         eof_pkg::SEL_A: term_site = site_a_ff;
         eof_pkg::SEL_B: term_site = site_b_ff;
         eof_pkg::SEL_I: term_site = site_i_ff;
         default:        term_site = site_a_ff;
      endcase
      term_spin = desc.same ? spin_s_ff : ~spin_s_ff;
   end

   // occupancy memory
   logic             mem [Depth];
   logic             rd_data_ff;
   logic [AddrW-1:0] rd_addr, wr_addr;
   logic             wr_data, wr_any;

   assign rd_addr = (term_spin ? SpinOff : '0) + site_mod[term_site];
   assign wr_any  = cmd.clr_step | cmd.wr_en;
   assign wr_addr = cmd.clr_step ? clr_addr_ff
                                 : ((spin_s_ff ? SpinOff : '0) + site_mod[site_a_ff]);
   assign wr_data = cmd.clr_step ? 1'b0 : occ_ff;

   always_ff @(posedge clock) begin
      if (wr_any) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // mode decode
   logic xfer_en, hop_pos, hop_neg, mode_bad;

   always_comb begin
      xfer_en  = (mode_ff == eof_pkg::MODE_CA_XFER) || (mode_ff == eof_pkg::MODE_AC_XFER);
      hop_pos  = (mode_ff == eof_pkg::MODE_CA) || (mode_ff == eof_pkg::MODE_CA_XFER);
      hop_neg  = (mode_ff == eof_pkg::MODE_AC) || (mode_ff == eof_pkg::MODE_AC_XFER);
      mode_bad = (mode_ff > eof_pkg::MODE_AC_XFER);
   end

   // term value: stored bit plus delta corrections, range -2..3
   logic signed [2:0] xfer_part, hop_diff, hop_part, term_val;

   always_comb begin
      xfer_part = 3'sd0;
      if (xfer_en && (spin_u_ff == term_spin)) begin
         xfer_part = $signed({2'b00, term_site == site_m_ff})
                   - $signed({2'b00, term_site == site_n_ff});
      end
      hop_diff = $signed({2'b00, term_site == site_i_ff})
               - $signed({2'b00, term_site == site_j_ff});
      hop_part = 3'sd0;
      if (desc.same && hop_pos) begin
         hop_part = hop_diff;
      end else if (desc.same && hop_neg) begin
         hop_part = -hop_diff;
      end
      term_val = $signed({2'b00, rd_data_ff}) + xfer_part + hop_part;
   end

   // running product
   logic signed [5:0] acc_ff, acc_in;
   logic signed [8:0] prod;

   assign prod = 9'(acc_ff) * 9'(term_val);

   always_comb begin
      acc_in = acc_ff;
      if (cmd.load) begin
         acc_in = 6'sd1;
      end else if (cmd.acc_en) begin
         acc_in = $signed(prod[5:0]);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // result registers
   logic signed [5:0] factor_ff;
   logic              bad_ff;

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         factor_ff <= ((type_ff == eof_pkg::REQ_WRITE) || mode_bad) ? 6'sd0 : acc_ff;
         bad_ff    <= (type_ff == eof_pkg::REQ_EVAL) && mode_bad;
      end
   end

   assign rsp_factor   = factor_ff;
   assign rsp_bad_mode = bad_ff;

   always_comb begin
      status.is_write   = (type_ff == eof_pkg::REQ_WRITE);
      status.mode_bad   = mode_bad;
      status.term_count = eof_pkg::term_count(exc_ff, site_a_ff == site_b_ff);
      status.clr_last   = (clr_addr_ff == LastAddr);
   end

endmodule

>>> sv/eof_ctrl.sv
// Controller: sequences clearing, decode, per-term reads and result strobe.
`include "excitation_occupation_factor_defines.svh"

module eof_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   output logic                    rsp_valid,
   output eof_pkg::eof_cmd_type    cmd,
   input  eof_pkg::eof_status_type status
);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_DECODE = 3'd2;
   localparam logic [2:0] ST_READ   = 3'd3;
   localparam logic [2:0] ST_ACC    = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [1:0] k_ff, k_in;
   logic       valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      valid_in = 1'b0;
      cmd      = '0;
      cmd.term_idx = k_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            k_in = 2'd0;
            priority if (status.is_write) begin
               cmd.wr_en = 1'b1;
               state_in  = ST_FINISH;
            end else if (status.mode_bad || (status.term_count == 2'd0)) begin
               state_in  = ST_FINISH;
            end else begin
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc_en = 1'b1;
            k_in       = k_ff + 2'd1;
            if (k_ff == status.term_count - 2'd1) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            valid_in   = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         k_ff     <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

   `EOF_ASSERT_NEXT(a_strobe_single, clock, reset, valid_ff, !valid_ff, "result strobe held two cycles")
   `EOF_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accepted transaction did not raise busy")
   `EOF_ASSERT_IMPL(a_clear_quiet, clock, reset, state_ff == ST_CLEAR, !valid_ff && !cmd.rd_en, "activity during clear sweep")
   `EOF_ASSERT_IMPL(a_term_range, clock, reset, state_ff == ST_ACC, k_ff < status.term_count, "term index past term count")

endmodule

>>> sv/excitation_occupation_factor.sv
// Top level of the excitation occupation factor block: controller plus datapath.
//
//   channel   ports                         handshake
//   --------  ----------------------------  ------------------------------------
//   request   req_type .. req_spin_u         accepted on start && !busy
//   result    rsp_factor, rsp_bad_mode       valid while rsp_valid, one cycle
//
// Sequence: a write goes through decode, where the memory is written, and finish
//   to the strobe; an evaluate also does, for each of T occupation terms (0..3),
//   one read of the occupancy memory and one multiply step. Invalid mode codes
//   go from decode to finish. busy drops the cycle the result shows.
// Reset: synchronous; afterwards a clearing sweep zeroes the occupancy memory,
//   all 2*SITES entries, one entry per cycle, with busy high.
// Stalls: the receiver cannot stall; rsp_valid flags each result for one cycle.
module excitation_occupation_factor #(
   parameter int SITES = eof_pkg::SITES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_type,
   input  logic              req_occ_value,
   input  logic [2:0]        req_mode,
   input  logic [2:0]        req_exc_type,
   input  logic [5:0]        req_site_a,
   input  logic [5:0]        req_site_b,
   input  logic [5:0]        req_site_i,
   input  logic [5:0]        req_site_j,
   input  logic              req_spin_s,
   input  logic [5:0]        req_site_m,
   input  logic [5:0]        req_site_n,
   input  logic              req_spin_u,
   output logic              rsp_valid,
   output logic signed [5:0] rsp_factor,
   output logic              rsp_bad_mode
);

   // command and status between controller and datapath
   eof_pkg::eof_cmd_type    cmd;
   eof_pkg::eof_status_type status;

   eof_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   // request fields are latched on accept; results stay put until the next transaction
   eof_datapath #(
      .SITES (SITES)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_type      (req_type),
      .req_occ_value (req_occ_value),
      .req_mode      (req_mode),
      .req_exc_type  (req_exc_type),
      .req_site_a    (req_site_a),
      .req_site_b    (req_site_b),
      .req_site_i    (req_site_i),
      .req_site_j    (req_site_j),
      .req_spin_s    (req_spin_s),
      .req_site_m    (req_site_m),
      .req_site_n    (req_site_n),
      .req_spin_u    (req_spin_u),
      .rsp_factor    (rsp_factor),
      .rsp_bad_mode  (rsp_bad_mode)
   );

endmodule
